FILE: rtl/afc_pkg.sv
package afc_pkg;

  localparam int CHANNELS      = 8;
  localparam int TABLE_ENTRIES = 8;

  localparam int FUNC_W     = 2;
  localparam int CH_W       = 3;
  localparam int MEAS_W     = 10;
  localparam int IDX_W      = 3;
  localparam int WORD_W     = 16;
  localparam int THR_W      = 10;
  localparam int VAL_W      = WORD_W - THR_W;
  localparam int MASK_W     = 8;
  localparam int DLY_W      = 8;
  localparam int DELAYS_W   = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ENTRY_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int TBL_DEPTH  = CHANNELS * TABLE_ENTRIES;
  localparam int TBL_ADDR_W = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

  localparam logic [FUNC_W-1:0] FUNC_SERVICE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RESET   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAYS  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_DONE
  } afc_state_t;

  typedef struct packed {
    logic latch;
    logic apply;
    logic walk_start;
    logic step;
    logic commit;
    logic load_out;
  } afc_cmd_t;

  typedef struct packed {
    logic need_walk;
    logic hit;
    logic last;
  } afc_sts_t;

endpackage

FILE: rtl/afc_ctrl.sv
module afc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  afc_pkg::afc_sts_t sts,
  output afc_pkg::afc_cmd_t cmd
);
  import afc_pkg::*;

  afc_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.apply = 1'b1;
        if (sts.need_walk) begin
          cmd.walk_start = 1'b1;
          state_nxt      = ST_WALK;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_WALK: begin
        // first covering entry, or the last one on overrun
        if (sts.hit || sts.last) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/afc_dpath.sv
module afc_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  afc_pkg::afc_cmd_t                cmd,
  output afc_pkg::afc_sts_t                sts,
  input  logic                             cfg_we,
  input  logic [afc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [afc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [afc_pkg::FUNC_W-1:0]       in_func,
  input  logic [afc_pkg::CH_W-1:0]         in_channel,
  input  logic                             in_measure_ready,
  input  logic [afc_pkg::MEAS_W-1:0]       in_measure,
  input  logic [afc_pkg::IDX_W-1:0]        in_entry_index,
  input  logic [afc_pkg::WORD_W-1:0]       in_table_word,
  output logic [afc_pkg::VAL_W-1:0]        out_feedback_value,
  output logic [afc_pkg::MASK_W-1:0]       out_ready_mask,
  output logic [afc_pkg::MASK_W-1:0]       out_internal_ready_mask,
  output logic                             out_adc_restart,
  output logic                             out_no_match
);
  import afc_pkg::*;

  // configuration
  logic [MASK_W-1:0]   enable_r;
  logic [MASK_W-1:0]   disable_r;
  logic [DELAYS_W-1:0] delays_r;

  // latched item
  logic [FUNC_W-1:0] func_r;
  logic [CH_W-1:0]   ch_r;
  logic              mready_r;
  logic [MEAS_W-1:0] meas_r;
  logic [IDX_W-1:0]  idx_r;
  logic [WORD_W-1:0] word_r;

  // channel state
  logic [VAL_W-1:0]  values_r [CHANNELS];
  logic [DLY_W-1:0]  delays_cnt_r [CHANNELS];
  logic [MASK_W-1:0] pending_r;
  logic [MASK_W-1:0] acq_r;
  logic [MASK_W-1:0] iacq_r;
  logic              restart_r;
  logic              miss_r;

  // threshold table
  logic [WORD_W-1:0]     tbl_mem [TBL_DEPTH];
  logic [WORD_W-1:0]     rd_data_r;
  logic [TBL_ADDR_W-1:0] rd_addr;
  logic [TBL_ADDR_W-1:0] wr_addr;
  logic [TBL_ADDR_W-1:0] ch_base;
  logic [ENTRY_W-1:0]    entry_r;
  logic                  tbl_we;

  // output registers
  logic [VAL_W-1:0]  out_fb_r;
  logic [MASK_W-1:0] out_acq_r;
  logic [MASK_W-1:0] out_iacq_r;
  logic              out_restart_r;
  logic              out_miss_r;

  logic                ch_ok;
  logic [CH_IDX_W-1:0] ch_idx;
  logic                svc_en;
  logic                dly_zero;
  logic                dis_bit;
  logic                load_ok;

  assign ch_ok    = 32'(ch_r) < CHANNELS;
  assign ch_idx   = ch_r[CH_IDX_W-1:0];
  assign svc_en   = ch_ok && (func_r == FUNC_SERVICE) && enable_r[ch_r];
  assign dly_zero = delays_cnt_r[ch_idx] == '0;
  assign dis_bit  = disable_r[ch_r];
  assign load_ok  = ch_ok && (func_r == FUNC_LOAD) && (32'(idx_r) < TABLE_ENTRIES);

  assign sts.need_walk = svc_en && dly_zero && mready_r && !dis_bit;
  assign sts.hit       = meas_r <= rd_data_r[THR_W-1:0];
  assign sts.last      = entry_r == ENTRY_W'(TABLE_ENTRIES - 1);

  assign ch_base = TBL_ADDR_W'(ch_idx) * TBL_ADDR_W'(TABLE_ENTRIES);
  assign wr_addr = ch_base + TBL_ADDR_W'(idx_r);
  assign tbl_we  = cmd.apply && load_ok;

  always_comb begin
    if (cmd.step) rd_addr = ch_base + TBL_ADDR_W'(entry_r) + TBL_ADDR_W'(1);
    else          rd_addr = ch_base;
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[wr_addr] <= word_r;
    rd_data_r <= tbl_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_start) entry_r <= '0;
    else if (cmd.step)  entry_r <= entry_r + ENTRY_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r   <= in_func;
      ch_r     <= in_channel;
      mready_r <= in_measure_ready;
      meas_r   <= in_measure;
      idx_r    <= in_entry_index;
      word_r   <= in_table_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= '0;
      disable_r <= '0;
      delays_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE:  enable_r  <= cfg_data[MASK_W-1:0];
        CFG_DISABLE: disable_r <= cfg_data[MASK_W-1:0];
        CFG_DELAYS:  delays_r  <= cfg_data[DELAYS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        values_r[c]     <= '0;
        delays_cnt_r[c] <= '0;
      end
      pending_r <= '0;
      acq_r     <= '0;
      iacq_r    <= '0;
      restart_r <= 1'b0;
      miss_r    <= 1'b0;
    end else begin
      if (cmd.apply) begin
        restart_r <= 1'b0;
        miss_r    <= 1'b0;
        if (svc_en) begin
          if (!dly_zero) begin
            delays_cnt_r[ch_idx] <= delays_cnt_r[ch_idx] - DLY_W'(1);
            pending_r[ch_r]      <= 1'b1;
          end else begin
            pending_r[ch_r] <= 1'b0;
            restart_r       <= pending_r[ch_r] || mready_r;
            if (mready_r) iacq_r[ch_r] <= 1'b1;
          end
        end else if (ch_ok && func_r == FUNC_RESET) begin
          delays_cnt_r[ch_idx] <= delays_r[ch_r*DLY_W +: DLY_W];
          iacq_r[ch_r]         <= 1'b0;
        end
      end
      if (cmd.commit) begin
        values_r[ch_idx] <= rd_data_r[WORD_W-1:THR_W];
        acq_r[ch_r]      <= 1'b1;
        miss_r           <= !sts.hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_fb_r      <= ch_ok ? values_r[ch_idx] : '0;
      out_acq_r     <= acq_r;
      out_iacq_r    <= iacq_r;
      out_restart_r <= restart_r;
      out_miss_r    <= miss_r;
    end
  end

  assign out_feedback_value      = out_fb_r;
  assign out_ready_mask          = out_acq_r;
  assign out_internal_ready_mask = out_iacq_r;
  assign out_adc_restart         = out_restart_r;
  assign out_no_match            = out_miss_r;

endmodule

FILE: rtl/analog_feedback_threshold_classifier_unit.sv
// an accepted item is latched, applied in EXEC and its result registered in DONE; a
// classifying service item first reads its channel's table in WALK, one entry at a time,
// until the first covering entry or the last; one item is in work at a time, held in DONE
// while a result waits; the next item is taken once the previous result is registered
// reset: synchronous active low rst_n clears control, configuration and channel state;
// threshold table words are undefined until loaded, no clearing pass
module analog_feedback_threshold_classifier_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [afc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [afc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [afc_pkg::FUNC_W-1:0]       in_func,
  input  logic [afc_pkg::CH_W-1:0]         in_channel,
  input  logic                             in_measure_ready,
  input  logic [afc_pkg::MEAS_W-1:0]       in_measure,
  input  logic [afc_pkg::IDX_W-1:0]        in_entry_index,
  input  logic [afc_pkg::WORD_W-1:0]       in_table_word,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [afc_pkg::VAL_W-1:0]        out_feedback_value,
  output logic [afc_pkg::MASK_W-1:0]       out_ready_mask,
  output logic [afc_pkg::MASK_W-1:0]       out_internal_ready_mask,
  output logic                             out_adc_restart,
  output logic                             out_no_match
);
  import afc_pkg::*;

  afc_cmd_t cmd;
  afc_sts_t sts;

  afc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  afc_dpath u_dpath (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .sts                     (sts),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .in_func                 (in_func),
    .in_channel              (in_channel),
    .in_measure_ready        (in_measure_ready),
    .in_measure              (in_measure),
    .in_entry_index          (in_entry_index),
    .in_table_word           (in_table_word),
    .out_feedback_value      (out_feedback_value),
    .out_ready_mask          (out_ready_mask),
    .out_internal_ready_mask (out_internal_ready_mask),
    .out_adc_restart         (out_adc_restart),
    .out_no_match            (out_no_match)
  );

endmodule

FILE: rtl/afc_check.sv
module afc_check (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [afc_pkg::VAL_W-1:0]   out_feedback_value,
  input logic [afc_pkg::MASK_W-1:0]  out_ready_mask,
  input logic                        out_adc_restart,
  input logic                        out_no_match
);

  // no result is shown in the cycle after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_feedback_value)
      && $stable(out_ready_mask))
    else $error("pending result changed before it was taken");

  // one item in flight: the controller leaves idle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in work");

  // a table miss only happens on a consumed measure, which restarts the adc
  a_miss_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_match |-> out_adc_restart)
    else $error("no_match without adc restart");

endmodule

bind analog_feedback_threshold_classifier_unit afc_check u_check (.*);
